// ----- design/clx_pkg.sv -----
// shared types, token codes and keyword matching for the c-minus lexer
`default_nettype none

package clx_pkg;

    localparam int STAGE_BITS   = 4;
    localparam int PREFIX_DEPTH = 6;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [3:0] ST_START   = 4'd0;
    localparam logic [3:0] ST_ID      = 4'd1;
    localparam logic [3:0] ST_NUM     = 4'd2;
    localparam logic [3:0] ST_SLASH   = 4'd3;
    localparam logic [3:0] ST_COMMENT = 4'd4;
    localparam logic [3:0] ST_STAR    = 4'd5;
    localparam logic [3:0] ST_LESS    = 4'd6;
    localparam logic [3:0] ST_GREATER = 4'd7;
    localparam logic [3:0] ST_ASSIGN  = 4'd8;
    localparam logic [3:0] ST_BANG    = 4'd9;

    localparam logic [4:0] K_END     = 5'd0;
    localparam logic [4:0] K_ID      = 5'd1;
    localparam logic [4:0] K_NUM     = 5'd2;
    localparam logic [4:0] K_VOID    = 5'd3;
    localparam logic [4:0] K_INT     = 5'd4;
    localparam logic [4:0] K_IF      = 5'd5;
    localparam logic [4:0] K_ELSE    = 5'd6;
    localparam logic [4:0] K_WHILE   = 5'd7;
    localparam logic [4:0] K_RETURN  = 5'd8;
    localparam logic [4:0] K_PLUS    = 5'd9;
    localparam logic [4:0] K_MINUS   = 5'd10;
    localparam logic [4:0] K_MUL     = 5'd11;
    localparam logic [4:0] K_DIV     = 5'd12;
    localparam logic [4:0] K_LT      = 5'd13;
    localparam logic [4:0] K_LE      = 5'd14;
    localparam logic [4:0] K_GT      = 5'd15;
    localparam logic [4:0] K_GE      = 5'd16;
    localparam logic [4:0] K_EQ      = 5'd17;
    localparam logic [4:0] K_NE      = 5'd18;
    localparam logic [4:0] K_ASSIGN  = 5'd19;
    localparam logic [4:0] K_SEMI    = 5'd20;
    localparam logic [4:0] K_COMMA   = 5'd21;
    localparam logic [4:0] K_LPAREN  = 5'd22;
    localparam logic [4:0] K_RPAREN  = 5'd23;
    localparam logic [4:0] K_LSQUARE = 5'd24;
    localparam logic [4:0] K_RSQUARE = 5'd25;
    localparam logic [4:0] K_LCURLY  = 5'd26;
    localparam logic [4:0] K_RCURLY  = 5'd27;
    localparam logic [4:0] K_ERROR   = 5'd28;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  len;
        logic [23:0] line;
        logic [7:0]  bad;
        logic        last;
    } t_result;

    typedef logic [PREFIX_DEPTH-1:0][7:0] t_prefix;

    function automatic logic [4:0] kw_kind(input t_prefix p, input logic [2:0] n,
                                           input logic fits);
        logic [4:0] k;
        k = K_ID;
        if (fits) begin
            if (n == 3'd4 && {p[0], p[1], p[2], p[3]} == "void") begin
                k = K_VOID;
            end else if (n == 3'd3 && {p[0], p[1], p[2]} == "int") begin
                k = K_INT;
            end else if (n == 3'd2 && {p[0], p[1]} == "if") begin
                k = K_IF;
            end else if (n == 3'd4 && {p[0], p[1], p[2], p[3]} == "else") begin
                k = K_ELSE;
            end else if (n == 3'd5 && {p[0], p[1], p[2], p[3], p[4]} == "while") begin
                k = K_WHILE;
            end else if (n == 3'd6 && {p[0], p[1], p[2], p[3], p[4], p[5]} == "return") begin
                k = K_RETURN;
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/clx_front.sv -----
// scanner automaton: takes one character per cycle while the queue has room and produces up to two results
`default_nettype none

module clx_front #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int LINE_BITS     = 24
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire  [7:0]           i_ch,
    input  wire                  i_space_ok,
    output logic                 o_ready,
    output logic [1:0]           o_push_cnt,
    output clx_pkg::t_result     o_res0,
    output clx_pkg::t_result     o_res1
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    logic [clx_pkg::STAGE_BITS-1:0] r_stage, n_stage;
    logic [LINE_BITS-1:0]           r_line, n_line;
    logic [LW-1:0]                  r_len, n_len;
    logic                           r_halt, n_halt;
    clx_pkg::t_prefix               r_prefix;

    logic        w_acc;
    logic        w_letter, w_digit;
    logic        w_pwr;
    logic [2:0]  w_pidx;
    logic        w_rescan;
    logic        w_se, w_ze;
    logic [4:0]  w_sk, w_zk;
    logic [7:0]  w_sl, w_zl, w_sb, w_zb;
    logic [15:0] w_len16;
    logic [31:0] w_line32;
    logic [4:0]  w_kw;

    assign o_ready  = i_space_ok;
    assign w_acc    = i_valid && i_space_ok;
    assign w_letter = (i_ch >= "a" && i_ch <= "z") || (i_ch >= "A" && i_ch <= "Z");
    assign w_digit  = i_ch >= "0" && i_ch <= "9";
    assign w_len16  = 16'(r_len);
    assign w_line32 = 32'(r_line);
    assign w_kw     = clx_pkg::kw_kind(r_prefix, r_len[2:0], (r_len >> 3) == '0);

    always_comb begin
        n_stage  = r_stage;
        n_line   = r_line;
        n_len    = r_len;
        n_halt   = r_halt;
        w_pwr    = 1'b0;
        w_pidx   = r_len[2:0];
        w_rescan = 1'b0;
        w_se     = 1'b0;
        w_sk     = clx_pkg::K_END;
        w_sl     = 8'd0;
        w_sb     = 8'd0;
        w_ze     = 1'b0;
        w_zk     = clx_pkg::K_END;
        w_zl     = 8'd0;
        w_zb     = 8'd0;
        if (w_acc && !r_halt) begin
            unique case (r_stage) inside
                clx_pkg::ST_ID, clx_pkg::ST_NUM: begin
                    if ((r_stage == clx_pkg::ST_ID) ? w_letter : w_digit) begin
                        w_pwr = r_len < LW'(clx_pkg::PREFIX_DEPTH);
                        if (r_len < LW'(MAX_TOKEN_LEN)) begin
                            n_len = r_len + LW'(1);
                        end
                    end else begin
                        w_se     = 1'b1;
                        w_sk     = (r_stage == clx_pkg::ST_ID) ? w_kw : clx_pkg::K_NUM;
                        w_sl     = w_len16[7:0];
                        w_rescan = 1'b1;
                    end
                end
                clx_pkg::ST_SLASH: begin
                    if (i_ch == "*") begin
                        n_stage = clx_pkg::ST_COMMENT;
                    end else begin
                        w_se     = 1'b1;
                        w_sk     = clx_pkg::K_DIV;
                        w_sl     = 8'd1;
                        w_rescan = 1'b1;
                    end
                end
                clx_pkg::ST_COMMENT, clx_pkg::ST_STAR: begin
                    if (i_ch == 8'd0) begin
                        n_stage = clx_pkg::ST_START;
                        w_se    = 1'b1;
                        w_sk    = clx_pkg::K_END;
                    end else if (i_ch == "*") begin
                        n_stage = clx_pkg::ST_STAR;
                    end else if (i_ch == "/" && r_stage == clx_pkg::ST_STAR) begin
                        n_stage = clx_pkg::ST_START;
                    end else begin
                        n_stage = clx_pkg::ST_COMMENT;
                        if (i_ch == 8'h0a && r_line != '1) begin
                            n_line = r_line + LINE_BITS'(1);
                        end
                    end
                end
                clx_pkg::ST_LESS, clx_pkg::ST_GREATER, clx_pkg::ST_ASSIGN: begin
                    n_stage = clx_pkg::ST_START;
                    w_se    = 1'b1;
                    if (i_ch == "=") begin
                        w_sl = 8'd2;
                        w_sk = (r_stage == clx_pkg::ST_LESS) ? clx_pkg::K_LE :
                               (r_stage == clx_pkg::ST_GREATER) ? clx_pkg::K_GE : clx_pkg::K_EQ;
                    end else begin
                        w_sl     = 8'd1;
                        w_sk     = (r_stage == clx_pkg::ST_LESS) ? clx_pkg::K_LT :
                                   (r_stage == clx_pkg::ST_GREATER) ? clx_pkg::K_GT :
                                   clx_pkg::K_ASSIGN;
                        w_rescan = 1'b1;
                    end
                end
                clx_pkg::ST_BANG: begin
                    n_stage = clx_pkg::ST_START;
                    w_se    = 1'b1;
                    if (i_ch == "=") begin
                        w_sk = clx_pkg::K_NE;
                        w_sl = 8'd2;
                    end else begin
                        w_sk   = clx_pkg::K_ERROR;
                        w_sb   = i_ch;
                        n_halt = 1'b1;
                    end
                end
                default: begin
                    w_rescan = 1'b1;
                end
            endcase

            if (w_rescan) begin
                n_stage = clx_pkg::ST_START;
                if (w_letter || w_digit) begin
                    w_pwr   = 1'b1;
                    w_pidx  = 3'd0;
                    n_len   = LW'(1);
                    n_stage = w_letter ? clx_pkg::ST_ID : clx_pkg::ST_NUM;
                end else begin
                    unique case (i_ch) inside
                        " ", 8'h09, 8'h0b, 8'h0c, 8'h0d: begin
                        end
                        8'h0a: begin
                            if (r_line != '1) begin
                                n_line = r_line + LINE_BITS'(1);
                            end
                        end
                        "/": n_stage = clx_pkg::ST_SLASH;
                        "<", ">", "=", "!": begin
                            w_pwr   = 1'b1;
                            w_pidx  = 3'd0;
                            n_len   = LW'(1);
                            n_stage = (i_ch == "<") ? clx_pkg::ST_LESS :
                                      (i_ch == ">") ? clx_pkg::ST_GREATER :
                                      (i_ch == "=") ? clx_pkg::ST_ASSIGN : clx_pkg::ST_BANG;
                        end
                        8'd0: begin
                            w_ze = 1'b1;
                            w_zk = clx_pkg::K_END;
                        end
                        "+": begin w_ze = 1'b1; w_zk = clx_pkg::K_PLUS;    w_zl = 8'd1; end
                        "-": begin w_ze = 1'b1; w_zk = clx_pkg::K_MINUS;   w_zl = 8'd1; end
                        "*": begin w_ze = 1'b1; w_zk = clx_pkg::K_MUL;     w_zl = 8'd1; end
                        ";": begin w_ze = 1'b1; w_zk = clx_pkg::K_SEMI;    w_zl = 8'd1; end
                        ",": begin w_ze = 1'b1; w_zk = clx_pkg::K_COMMA;   w_zl = 8'd1; end
                        "(": begin w_ze = 1'b1; w_zk = clx_pkg::K_LPAREN;  w_zl = 8'd1; end
                        ")": begin w_ze = 1'b1; w_zk = clx_pkg::K_RPAREN;  w_zl = 8'd1; end
                        "[": begin w_ze = 1'b1; w_zk = clx_pkg::K_LSQUARE; w_zl = 8'd1; end
                        "]": begin w_ze = 1'b1; w_zk = clx_pkg::K_RSQUARE; w_zl = 8'd1; end
                        "{": begin w_ze = 1'b1; w_zk = clx_pkg::K_LCURLY;  w_zl = 8'd1; end
                        "}": begin w_ze = 1'b1; w_zk = clx_pkg::K_RCURLY;  w_zl = 8'd1; end
                        default: begin
                            w_ze   = 1'b1;
                            w_zk   = clx_pkg::K_ERROR;
                            w_zb   = i_ch;
                            n_halt = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // results use the line count before this character
    always_comb begin
        o_res0.line = w_line32[23:0];
        o_res1.line = w_line32[23:0];
        o_res1.kind = w_zk;
        o_res1.len  = w_zl;
        o_res1.bad  = w_zb;
        o_res1.last = 1'b1;
        if (w_se) begin
            o_res0.kind = w_sk;
            o_res0.len  = w_sl;
            o_res0.bad  = w_sb;
            o_res0.last = !w_ze;
            o_push_cnt  = w_ze ? 2'd2 : 2'd1;
        end else begin
            o_res0.kind = w_zk;
            o_res0.len  = w_zl;
            o_res0.bad  = w_zb;
            o_res0.last = 1'b1;
            o_push_cnt  = w_ze ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= clx_pkg::ST_START;
            r_line  <= LINE_BITS'(1);
            r_len   <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_stage <= n_stage;
            r_line  <= n_line;
            r_len   <= n_len;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pwr) begin
            r_prefix[w_pidx] <= i_ch;
        end
    end

endmodule

`default_nettype wire

// ----- design/clx_fifo.sv -----
// short result queue: up to two writes and one read per cycle
`default_nettype none

module clx_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [1:0]           i_push_cnt,
    input  clx_pkg::t_result     i_res0,
    input  clx_pkg::t_result     i_res1,
    output logic                 o_space_ok,
    output logic                 o_nonempty,
    output clx_pkg::t_result     o_head,
    input  wire                  i_pop
);

    localparam int PW = $clog2(clx_pkg::FIFO_DEPTH);
    localparam int CW = PW + 1;

    clx_pkg::t_result r_mem [clx_pkg::FIFO_DEPTH];
    logic [PW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] w_wr1;

    assign w_wr1      = r_wr + PW'(1);
    assign o_space_ok = r_cnt <= CW'(clx_pkg::FIFO_DEPTH - 2);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + PW'(i_push_cnt);
        n_rd  = i_pop ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt + CW'(i_push_cnt) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

endmodule

`default_nettype wire

// ----- design/clx_out.sv -----
// output register stage driving the result stream
`default_nettype none

module clx_out (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_nonempty,
    input  clx_pkg::t_result     i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output clx_pkg::t_result     o_res
);

    logic             r_valid;
    clx_pkg::t_result r_res;

    assign o_pop   = i_nonempty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

endmodule

`default_nettype wire

// ----- design/c_minus_lexer.sv -----
// c-minus lexer top level
//
// Streams one source byte per item on the slave side and returns tokens on the
// master side: kind in tuser, length, line and offending byte in tdata, and
// tlast on the final token caused by a byte. A byte is taken every cycle while
// the four-entry token queue has room for two tokens; a byte that ends one token
// and starts another writes two entries, so with bytes back to back and the
// output always ready, double tokens build up in the queue until the input
// pauses. Results pass through the token queue and then a register stage
// before they are presented. Byte 0 gives an end token; an invalid byte gives
// an error token and the block swallows all further bytes until reset.
`default_nettype none

module c_minus_lexer #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int LINE_BITS     = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // ch
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // token_length, line_number, bad_char
    output logic [4:0]  o_m_axis_tuser,   // token_kind
    output logic        o_m_axis_tlast
);

    logic             w_space_ok;
    logic [1:0]       w_push_cnt;
    clx_pkg::t_result w_res0, w_res1, w_head, w_out;
    logic             w_nonempty, w_pop;

    clx_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_ch       (i_s_axis_tdata),
        .i_space_ok (w_space_ok),
        .o_ready    (o_s_axis_tready),
        .o_push_cnt (w_push_cnt),
        .o_res0     (w_res0),
        .o_res1     (w_res1)
    );

    clx_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_res0     (w_res0),
        .i_res1     (w_res1),
        .o_space_ok (w_space_ok),
        .o_nonempty (w_nonempty),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    clx_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (w_nonempty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res      (w_out)
    );

    assign o_m_axis_tdata = {w_out.bad, w_out.line, w_out.len};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.last;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench for the c-minus lexer: random source text in, every token checked against a scanner model
module tb;
    import clx_pkg::*;

    localparam int MAX_LEN     = 255;
    localparam int LINE_W      = 24;
    localparam int MAX_WAIT    = 19;
    localparam int END_PAUSE   = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PAUSE_MARK  = -1;
    localparam int SOURCE_LEN  = 2030;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_EQ    = "=";

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = '0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire         m_last;
    wire  [39:0] m_data;
    wire  [4:0]  m_user;

    c_minus_lexer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // scanner state
    logic [3:0]        scan_st  = ST_START;
    logic [LINE_W-1:0] line_cnt = 1;
    int                tok_len  = 0;
    logic [47:0]       tok_head = '0;
    bit                stopped  = 1'b0;
    int                fresh_tokens;

    t_result token_q[$];
    int      source_q[$];

    int errors      = 0;
    int bytes_in    = 0;
    int tokens_seen = 0;
    int doubles     = 0;
    int cycles      = 0;

    string kw_words[6] = '{"void", "int", "if", "else", "while", "return"};
    string op_words[19] = '{"+", "-", "*", "/", "<", "<=", ">", ">=", "==", "!=", "=",
                            ";", ",", "(", ")", "[", "]", "{", "}"};
    string marks = "+-*/<>=!;,()[]{}";

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        if (errors < 100) $display("MISMATCH: %s", msg);
        errors++;
    endtask

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit starts_token(logic [7:0] c);
        if (is_alpha(c) || is_num(c) || c == CH_NUL || c == CH_SP) return 1'b1;
        if (c >= CH_TAB && c <= CH_CR) return 1'b1;
        for (int i = 0; i < marks.len(); i++) begin
            if (c == marks[i]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [4:0] word_kind(int n, logic [47:0] w);
        if (n == 4 && w[31:0] == "void") return K_VOID;
        if (n == 3 && w[23:0] == "int") return K_INT;
        if (n == 2 && w[15:0] == "if") return K_IF;
        if (n == 4 && w[31:0] == "else") return K_ELSE;
        if (n == 5 && w[39:0] == "while") return K_WHILE;
        if (n == 6 && w == "return") return K_RETURN;
        return K_ID;
    endfunction

    task automatic add_token(logic [4:0] kind, int len, logic [7:0] bad);
        t_result r;
        r.kind = kind;
        r.len  = len[7:0];
        r.line = line_cnt;
        r.bad  = bad;
        r.last = 1'b0;
        token_q.push_back(r);
        fresh_tokens++;
    endtask

    task automatic take_char(logic [7:0] c);
        if (tok_len < PREFIX_DEPTH) tok_head = {tok_head[39:0], c};
        if (tok_len < MAX_LEN) tok_len++;
    endtask

    task automatic next_line();
        if (line_cnt != '1) line_cnt++;
    endtask

    task automatic halt_on(logic [7:0] c);
        add_token(K_ERROR, 0, c);
        stopped = 1'b1;
        scan_st = ST_START;
    endtask

    task automatic scan_fresh(logic [7:0] c);
        logic [4:0] one;
        one      = K_ERROR;
        tok_len  = 0;
        tok_head = '0;
        scan_st  = ST_START;
        if (is_alpha(c)) begin
            take_char(c);
            scan_st = ST_ID;
        end else if (is_num(c)) begin
            take_char(c);
            scan_st = ST_NUM;
        end else begin
            case (c)
                CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: ;
                CH_LF: next_line();
                CH_SLASH: scan_st = ST_SLASH;
                "<": begin
                    take_char(c);
                    scan_st = ST_LESS;
                end
                ">": begin
                    take_char(c);
                    scan_st = ST_GREATER;
                end
                CH_EQ: begin
                    take_char(c);
                    scan_st = ST_ASSIGN;
                end
                CH_BANG: begin
                    take_char(c);
                    scan_st = ST_BANG;
                end
                CH_NUL: add_token(K_END, 0, 8'd0);
                "+": one = K_PLUS;
                "-": one = K_MINUS;
                CH_STAR: one = K_MUL;
                ";": one = K_SEMI;
                ",": one = K_COMMA;
                "(": one = K_LPAREN;
                ")": one = K_RPAREN;
                "[": one = K_LSQUARE;
                "]": one = K_RSQUARE;
                "{": one = K_LCURLY;
                "}": one = K_RCURLY;
                default: halt_on(c);
            endcase
            if (one != K_ERROR) add_token(one, 1, 8'd0);
        end
    endtask

    task automatic scan_byte(logic [7:0] c);
        bit         again;
        logic [4:0] lone;
        logic [4:0] pair;
        t_result    r;
        again        = 1'b0;
        fresh_tokens = 0;
        if (stopped) return;
        case (scan_st)
            ST_ID: begin
                if (is_alpha(c)) begin
                    take_char(c);
                end else begin
                    add_token(word_kind(tok_len, tok_head), tok_len, 8'd0);
                    again = 1'b1;
                end
            end
            ST_NUM: begin
                if (is_num(c)) begin
                    take_char(c);
                end else begin
                    add_token(K_NUM, tok_len, 8'd0);
                    again = 1'b1;
                end
            end
            ST_SLASH: begin
                if (c == CH_STAR) begin
                    scan_st = ST_COMMENT;
                end else begin
                    add_token(K_DIV, 1, 8'd0);
                    again = 1'b1;
                end
            end
            ST_COMMENT, ST_STAR: begin
                if (c == CH_NUL) begin
                    scan_st = ST_START;
                    add_token(K_END, 0, 8'd0);
                end else if (c == CH_STAR) begin
                    scan_st = ST_STAR;
                end else if (c == CH_SLASH && scan_st == ST_STAR) begin
                    scan_st = ST_START;
                end else begin
                    scan_st = ST_COMMENT;
                    if (c == CH_LF) next_line();
                end
            end
            ST_LESS, ST_GREATER, ST_ASSIGN: begin
                lone = scan_st == ST_LESS ? K_LT : scan_st == ST_GREATER ? K_GT : K_ASSIGN;
                pair = scan_st == ST_LESS ? K_LE : scan_st == ST_GREATER ? K_GE : K_EQ;
                scan_st = ST_START;
                if (c == CH_EQ) begin
                    add_token(pair, 2, 8'd0);
                end else begin
                    add_token(lone, 1, 8'd0);
                    again = 1'b1;
                end
            end
            ST_BANG: begin
                scan_st = ST_START;
                if (c == CH_EQ) add_token(K_NE, 2, 8'd0);
                else halt_on(c);
            end
            default: again = 1'b1;
        endcase
        if (again) scan_fresh(c);
        if (fresh_tokens > 0) begin
            r = token_q.pop_back();
            r.last = 1'b1;
            token_q.push_back(r);
        end
        if (fresh_tokens > 1) doubles++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) source_q.push_back(int'(s[i]));
    endtask

    task automatic push_letters(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) source_q.push_back($urandom_range("a", "z"));
            else source_q.push_back($urandom_range("A", "Z"));
        end
    endtask

    // one well-formed piece of source text with random content
    task automatic gen_piece();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            w = kw_words[$urandom_range(0, 5)];
            n = $urandom_range(0, 3);
            if (n == 0) w = w.substr(0, w.len() - 2);
            push_text(w);
            if (n == 1) push_letters(1);
        end else if (pick < 35) begin
            if ($urandom_range(0, 99) == 0) push_letters($urandom_range(250, 300));
            else push_letters($urandom_range(1, 8));
        end else if (pick < 50) begin
            n = $urandom_range(0, 99) == 0 ? 270 : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) source_q.push_back($urandom_range("0", "9"));
        end else if (pick < 75) begin
            push_text(op_words[$urandom_range(0, 18)]);
        end else if (pick < 85) begin
            case ($urandom_range(0, 7))
                0: source_q.push_back(CH_TAB);
                1: source_q.push_back(CH_VT);
                2: source_q.push_back(CH_FF);
                3: source_q.push_back(CH_CR);
                4, 5: source_q.push_back(CH_LF);
                default: source_q.push_back(CH_SP);
            endcase
        end else if (pick < 93) begin
            push_text("/*");
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: source_q.push_back(CH_STAR);
                    2: source_q.push_back(CH_LF);
                    default: source_q.push_back($urandom_range(1, 255));
                endcase
            end
            if ($urandom_range(0, 9) == 0) source_q.push_back(CH_NUL);
            else push_text($urandom_range(0, 1) ? "*/" : "**/");
        end else if (pick < 96) begin
            source_q.push_back(CH_NUL);
        end else begin
            do n = $urandom_range(1, 127);
            while (!starts_token(n[7:0]) || n == CH_BANG);
            source_q.push_back(n);
        end
    endtask

    // byte driver
    int send_gap  = 0;
    bit send_calm = 1'b0;
    always @(posedge i_clk) begin
        bit         busy;
        logic [7:0] nxt;
        busy = s_valid;
        nxt  = s_data;
        if (!i_rst_n) begin
            busy = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_data);
                bytes_in++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (source_q.size() > 0) begin
                    if (source_q[0] == PAUSE_MARK) begin
                        if (token_q.size() == 0) void'(source_q.pop_front());
                    end else begin
                        nxt  = 8'(source_q.pop_front());
                        busy = 1'b1;
                        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
                        send_gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
                    end
                end
            end
        end
        s_valid <= busy;
        s_data  <= nxt;
    end

    // token monitor
    int recv_gap  = 0;
    bit recv_calm = 1'b0;
    always @(posedge i_clk) begin
        bit      rdy;
        t_result want;
        rdy = m_ready;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                tokens_seen++;
                if (token_q.size() == 0) begin
                    report($sformatf("token %0d kind %0d arrived with nothing expected",
                                     tokens_seen, m_user));
                end else begin
                    want = token_q.pop_front();
                    if (m_user !== want.kind)
                        report($sformatf("token %0d kind %0d, expected %0d",
                                         tokens_seen, m_user, want.kind));
                    if (m_data[7:0] !== want.len)
                        report($sformatf("token %0d length %0d, expected %0d",
                                         tokens_seen, m_data[7:0], want.len));
                    if (m_data[31:8] !== want.line)
                        report($sformatf("token %0d line %0d, expected %0d",
                                         tokens_seen, m_data[31:8], want.line));
                    if (m_data[39:32] !== want.bad)
                        report($sformatf("token %0d bad byte %0d, expected %0d",
                                         tokens_seen, m_data[39:32], want.bad));
                    if (m_last !== want.last)
                        report($sformatf("token %0d last %0b, expected %0b",
                                         tokens_seen, m_last, want.last));
                end
                if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
                recv_gap = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
                rdy = recv_gap == 0;
            end else if (!m_ready) begin
                if (recv_gap > 0) recv_gap--;
                rdy = recv_gap == 0;
            end
        end
        m_ready <= rdy;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still expected", cycles,
                     token_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int c;
        push_text("int f;/*\n**/a<=9!=b>=c==d=e");
        source_q.push_back(CH_NUL);
        push_text("x/*");
        source_q.push_back(CH_NUL);
        source_q.push_back(CH_NUL);
        source_q.push_back(PAUSE_MARK);
        while (source_q.size() < SOURCE_LEN / 2) gen_piece();
        source_q.push_back(PAUSE_MARK);
        while (source_q.size() < SOURCE_LEN) gen_piece();

        // an error halts the scanner for good, so it closes the run
        if ($urandom_range(0, 1)) source_q.push_back(CH_SP);
        case ($urandom_range(0, 2))
            0: source_q.push_back($urandom_range(128, 255));
            1: begin
                do c = $urandom_range(1, 127);
                while (starts_token(c[7:0]));
                source_q.push_back(c);
            end
            default: begin
                source_q.push_back(CH_BANG);
                do c = $urandom_range(0, 255);
                while (c == CH_EQ);
                source_q.push_back(c);
            end
        endcase
        source_q.push_back(8'hFF);
        source_q.push_back(8'h80);
        for (int i = 0; i < 6; i++) source_q.push_back($urandom_range(0, 255));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (source_q.size() > 0 || s_valid) @(posedge i_clk);
        while (token_q.size() > 0) @(posedge i_clk);
        repeat (END_PAUSE) @(posedge i_clk);

        $display("scanned %0d bytes into %0d tokens, %0d bytes closed one token and opened another",
                 bytes_in, tokens_seen, doubles);
        $display("reached line %0d, drained the output twice mid-run, ended on a halting error",
                 line_cnt);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- c_minus_lexer.f -----
design/clx_pkg.sv
design/clx_front.sv
design/clx_fifo.sv
design/clx_out.sv
design/c_minus_lexer.sv
verif/tb.sv
